// ===== hdl/code_length_run_encoder_assert.svh =====
// Assertion helpers for the code-length run encoder.
`ifndef CODE_LENGTH_RUN_ENCODER_ASSERT_SVH
`define CODE_LENGTH_RUN_ENCODER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define CLRE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define CLRE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/clre_pkg.sv =====
`timescale 1ns / 1ps

package clre_pkg;

  localparam int ZeroRunCap = 138;
  localparam int LongZeroMin = 11;
  localparam int ShortRunMin = 3;
  localparam int RepeatCap = 6;

  localparam logic [4:0] SymRepeat = 5'd16;
  localparam logic [4:0] SymZeros3 = 5'd17;
  localparam logic [4:0] SymZeros11 = 5'd18;

  localparam logic [2:0] BitsRepeat = 3'd2;
  localparam logic [2:0] BitsZeros3 = 3'd3;
  localparam logic [2:0] BitsZeros11 = 3'd7;

  localparam int MaxPerItem = 3;
  localparam int QDepth = 8;
  localparam int QAw = $clog2(QDepth);
  localparam int QCntW = $clog2(QDepth + 1);

  typedef struct packed {
    logic [4:0] sym;
    logic [2:0] nbits;
    logic [6:0] val;
    logic       last;
  } entry_t;

  typedef struct packed {
    entry_t [1:0] ent;
    logic   [1:0] n;
  } flush_t;

  function automatic entry_t make_entry(logic [4:0] sym, logic [2:0] nbits, logic [6:0] val);
    entry_t e;
    e.sym   = sym;
    e.nbits = nbits;
    e.val   = val;
    e.last  = 1'b0;
    return e;
  endfunction

  // Entries that close out a pending run.
  function automatic flush_t run_flush(logic active, logic [3:0] value, logic [7:0] count);
    flush_t f;
    entry_t lit;
    f = '0;
    lit = make_entry({1'b0, value}, 3'd0, 7'd0);
    if (active) begin
      if (value == 4'd0) begin
        if (count >= 8'(LongZeroMin)) begin
          f.ent[0] = make_entry(SymZeros11, BitsZeros11, 7'(count - 8'(LongZeroMin)));
          f.n = 2'd1;
        end else if (count >= 8'(ShortRunMin)) begin
          f.ent[0] = make_entry(SymZeros3, BitsZeros3, 7'(count - 8'(ShortRunMin)));
          f.n = 2'd1;
        end else begin
          f.ent[0] = lit;
          f.ent[1] = lit;
          f.n = count[1:0];
        end
      end else begin
        if (count >= 8'(ShortRunMin)) begin
          f.ent[0] = make_entry(SymRepeat, BitsRepeat, 7'(count - 8'(ShortRunMin)));
          f.n = 2'd1;
        end else begin
          f.ent[0] = lit;
          f.ent[1] = lit;
          f.n = count[1:0];
        end
      end
    end
    return f;
  endfunction

endpackage

// ===== hdl/code_length_run_encoder.sv =====
`timescale 1ns / 1ps
// Entries are written into a registered output queue of 8 entries when a code length is accepted.
// Throughput: one code length per cycle while in_stall is low; each gives 0 to 3 entries, drained
// one per cycle while out_stall is low. The queue stalls input when fewer than 3 slots are free.
// Reset (rst, synchronous): clears the pending run and empties the output queue.
`include "code_length_run_encoder_assert.svh"

module code_length_run_encoder
  import clre_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] code_length,
  input  logic       final_length,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] rle_symbol,
  output logic [2:0] extra_bit_count,
  output logic [6:0] extra_bits_value,
  output logic       last_entry
);

  logic             run_active, run_active_next;
  logic [3:0]       run_value, run_value_next;
  logic [7:0]       run_count, run_count_next;

  entry_t           q [QDepth];
  logic [QAw-1:0]   wr_ptr, rd_ptr;
  logic [QCntW-1:0] fill;

  logic             in_accept, pop;
  logic             match, capped;
  logic [7:0]       count_inc;
  flush_t           fl_a, fl_b;
  entry_t [2:0]     ent;
  logic [1:0]       n;

  assign in_stall  = fill > QCntW'(QDepth - MaxPerItem);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = fill != '0;
  assign pop       = out_valid && !out_stall;

  always_comb begin
    match     = run_active && (code_length == run_value);
    count_inc = run_count + 8'd1;
    capped    = (code_length == 4'd0) ? (count_inc == 8'(ZeroRunCap))
                                      : (count_inc == 8'(RepeatCap));
    ent = '0;
    n   = '0;
    run_active_next = run_active;
    run_value_next  = run_value;
    run_count_next  = run_count;
    fl_a = '0;
    fl_b = '0;
    if (match) begin
      if (capped) begin
        fl_a = run_flush(1'b1, run_value, count_inc);
        run_active_next = 1'b0;
        run_value_next  = '0;
        run_count_next  = '0;
      end else begin
        run_count_next = count_inc;
      end
    end else begin
      fl_a = run_flush(run_active, run_value, run_count);
      run_active_next = 1'b1;
      run_value_next  = code_length;
      run_count_next  = (code_length == 4'd0) ? 8'd1 : 8'd0;
    end
    for (int k = 0; k < 2; k++) begin
      if (2'(k) < fl_a.n) begin
        ent[n] = fl_a.ent[k];
        n = n + 2'd1;
      end
    end
    if (!match && code_length != 4'd0) begin
      ent[n] = make_entry({1'b0, code_length}, 3'd0, 7'd0);
      n = n + 2'd1;
    end
    if (final_length) begin
      fl_b = run_flush(run_active_next, run_value_next, run_count_next);
      for (int k = 0; k < 2; k++) begin
        if (2'(k) < fl_b.n) begin
          ent[n] = fl_b.ent[k];
          n = n + 2'd1;
        end
      end
      run_active_next = 1'b0;
      run_value_next  = '0;
      run_count_next  = '0;
      if (n != 2'd0) begin
        ent[n - 2'd1].last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_active <= 1'b0;
      run_value  <= '0;
      run_count  <= '0;
    end else if (in_accept) begin
      run_active <= run_active_next;
      run_value  <= run_value_next;
      run_count  <= run_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      for (int k = 0; k < MaxPerItem; k++) begin
        if (2'(k) < n) begin
          q[wr_ptr + QAw'(k)] <= ent[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (in_accept) begin
        wr_ptr <= wr_ptr + QAw'(n);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAw'(1);
      end
      fill <= fill + (in_accept ? QCntW'(n) : QCntW'(0)) - (pop ? QCntW'(1) : QCntW'(0));
    end
  end

  assign rle_symbol       = q[rd_ptr].sym;
  assign extra_bit_count  = q[rd_ptr].nbits;
  assign extra_bits_value = q[rd_ptr].val;
  assign last_entry       = q[rd_ptr].last;

  `CLRE_ASSERT_NOW(a_fill_bound, 1'b1, fill <= QCntW'(QDepth), "output queue overfilled")
  `CLRE_ASSERT_NOW(a_idle_clear, !run_active, {run_value, run_count} == '0, "stale idle run")
  `CLRE_ASSERT_NOW(a_zero_cap, 1'b1, run_count < 8'(ZeroRunCap), "run count beyond zero cap")
  `CLRE_ASSERT_NEXT(a_final_out, in_accept && final_length, fill != '0, "no final entry")

endmodule
